// ===== hdl/qtci_pkg.sv =====
// Shared types, constants and helper functions for the quadtree cell index block.
package qtci_pkg;

   localparam int COORD_W     = 16;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_BITS    = COORD_W / DIV_STAGES;
   localparam int LEVEL_LIMIT = 8;

   localparam logic [2:0] CSR_SPACE_LEFT   = 3'd0;
   localparam logic [2:0] CSR_SPACE_TOP    = 3'd1;
   localparam logic [2:0] CSR_SPACE_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_SPACE_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_TREE_DEPTH   = 3'd4;

   typedef struct packed {
      logic signed [15:0] rect_left;
      logic signed [15:0] rect_top;
      logic signed [15:0] rect_right;
      logic signed [15:0] rect_bottom;
   } req_type;

   typedef struct packed {
      logic        registered;
      logic        outside_space;
      logic [14:0] cell_index;
      logic [2:0]  node_level;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic outside;
   } ctl_type;

   function automatic logic [14:0] level_offset(input logic [3:0] k);
      logic [14:0] r;
      unique case (k)
         4'd0:    r = 15'd0;
         4'd1:    r = 15'd1;
         4'd2:    r = 15'd5;
         4'd3:    r = 15'd21;
         4'd4:    r = 15'd85;
         4'd5:    r = 15'd341;
         4'd6:    r = 15'd1365;
         4'd7:    r = 15'd5461;
         4'd8:    r = 15'd21845;
         default: r = 15'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] spread8(input logic [7:0] n);
      logic [15:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[2*i] = n[i];
      end
      return r;
   endfunction

endpackage

// ===== hdl/qtci_divider.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module qtci_divider (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] dvd,
   input  logic [15:0] dvs,
   output logic [15:0] quo
);
   import qtci_pkg::*;

   logic [15:0] rem_ff [DIV_STAGES];
   logic [15:0] dvd_ff [DIV_STAGES];
   logic [15:0] rem_in [DIV_STAGES];
   logic [15:0] dvd_in [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [15:0] rem_src;
      logic [15:0] dvd_src;
      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign dvd_src = dvd;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign dvd_src = dvd_ff[s-1];
      end

      always_comb begin
         logic [16:0] t;
         logic [15:0] r;
         logic [15:0] d;
         r = rem_src;
         d = dvd_src;
         for (int b = 0; b < DIV_BITS; b++) begin
            t = {r, d[15]};
            if (t >= {1'b0, dvs}) begin
               t = t - {1'b0, dvs};
               d = {d[14:0], 1'b1};
            end else begin
               d = {d[14:0], 1'b0};
            end
            r = t[15:0];
         end
         rem_in[s] = r;
         dvd_in[s] = d;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            dvd_ff[s] <= dvd_in[s];
         end
      end
   end

   assign quo = dvd_ff[DIV_STAGES-1];

endmodule

// ===== hdl/qtci_locate.sv =====
// Morton codes, level search and node index, two register stages.
module qtci_locate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  qtci_pkg::ctl_type     ctl,
   input  logic [15:0]           lx,
   input  logic [15:0]           ty,
   input  logic [15:0]           rx,
   input  logic [15:0]           by,
   input  logic [2:0]            depth,
   output logic                  out_valid,
   output qtci_pkg::rsp_type     out_rsp
);
   import qtci_pkg::*;

   ctl_type     a_ctl_ff, a_ctl_in;
   logic [15:0] a_rb_ff, a_rb_in;
   logic [2:0]  a_lvl_ff, a_lvl_in;
   logic        b_valid_ff;
   rsp_type     b_rsp_ff, b_rsp_in;

   always_comb begin
      logic [15:0] lt;
      logic [15:0] diff;
      logic [15:0] sl, st, sr, sb;
      sl       = spread8(lx[7:0]);
      st       = spread8(ty[7:0]);
      sr       = spread8(rx[7:0]);
      sb       = spread8(by[7:0]);
      lt       = sl | {st[14:0], 1'b0};
      a_rb_in  = sr | {sb[14:0], 1'b0};
      diff     = lt ^ a_rb_in;
      a_lvl_in = '0;
      for (int i = 0; i < 7; i++) begin
         if ((3'(i) < depth) && (diff[2*i +: 2] != 2'b00)) begin
            a_lvl_in = 3'(i + 1);
         end
      end
      a_ctl_in = ctl;
   end

   always_comb begin
      logic [16:0] idx;
      logic [14:0] cells;
      idx   = {1'b0, a_rb_ff >> {a_lvl_ff, 1'b0}}
            + {2'b00, level_offset({1'b0, depth - a_lvl_ff})};
      cells = level_offset({1'b0, depth} + 4'd1);
      b_rsp_in = '0;
      if (a_ctl_ff.outside) begin
         b_rsp_in.outside_space = 1'b1;
      end else begin
         b_rsp_in.node_level = a_lvl_ff;
         if (idx < {2'b00, cells}) begin
            b_rsp_in.registered = 1'b1;
            b_rsp_in.cell_index = idx[14:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_ctl_ff   <= a_ctl_in;
         b_valid_ff <= a_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rb_ff  <= a_rb_in;
         a_lvl_ff <= a_lvl_in;
         b_rsp_ff <= b_rsp_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rsp   = b_rsp_ff;

endmodule

// ===== hdl/quadtree_cell_index.sv =====
// Top level of the linear quadtree cell index block.
//
//   port group  dir  payload          notes
//   req_*       in   qtci_pkg::req_type  bounding rectangle
//   rsp_*       out  qtci_pkg::rsp_type  cell index result
//   csr_*       in   index, data      config write, always ready
//
// One transaction per cycle while not stalled; stages: offset stage, four
// divider stages of 4 quotient bits, Morton/level stage, index stage.
// Synchronous reset clears valid bits and loads the register defaults.
// A stalled result freezes the pipe; req_ready = !rsp_valid || rsp_ready.
module quadtree_cell_index (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qtci_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qtci_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import qtci_pkg::*;

   logic signed [15:0] left_ff, top_ff;
   logic [15:0]        width_ff, height_ff;
   logic [2:0]         depth_ff;
   logic [2:0]         depth_eff;
   logic [15:0]        ux, uy;
   logic               advance;

   ctl_type     ctl_ff [DIV_STAGES+1];
   ctl_type     ctl_in;
   logic [15:0] ox_ff [4];
   logic [15:0] ox_in [4];
   logic [15:0] quo [4];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= -16'sd100;
         top_ff    <= -16'sd100;
         width_ff  <= 16'd840;
         height_ff <= 16'd840;
         depth_ff  <= 3'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPACE_LEFT:   left_ff   <= csr_data;
            CSR_SPACE_TOP:    top_ff    <= csr_data;
            CSR_SPACE_WIDTH:  width_ff  <= csr_data;
            CSR_SPACE_HEIGHT: height_ff <= csr_data;
            CSR_TREE_DEPTH:   depth_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [15:0] sx, sy;
      depth_eff = ({1'b0, depth_ff} >= 4'(LEVEL_LIMIT)) ? 3'(LEVEL_LIMIT - 1) : depth_ff;
      sx = width_ff >> depth_eff;
      sy = height_ff >> depth_eff;
      ux = (sx == '0) ? 16'd1 : sx;
      uy = (sy == '0) ? 16'd1 : sy;
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      logic signed [16:0] d [4];
      logic signed [17:0] right_edge, bottom_edge;
      d[0] = 17'(req_data.rect_left)   - 17'(left_ff);
      d[1] = 17'(req_data.rect_top)    - 17'(top_ff);
      d[2] = 17'(req_data.rect_right)  - 17'(left_ff);
      d[3] = 17'(req_data.rect_bottom) - 17'(top_ff);
      for (int c = 0; c < 4; c++) begin
         ox_in[c] = d[c][16] ? 16'd0 : d[c][15:0];
      end
      right_edge  = 18'(left_ff) + $signed({2'b00, width_ff});
      bottom_edge = 18'(top_ff)  + $signed({2'b00, height_ff});
      ctl_in.valid   = req_valid;
      ctl_in.outside = (req_data.rect_right < left_ff) || (req_data.rect_bottom < top_ff)
                    || (18'(req_data.rect_left) > right_edge)
                    || (18'(req_data.rect_top) > bottom_edge);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 4; c++) begin
            ox_ff[c] <= ox_in[c];
         end
      end
   end

   for (genvar c = 0; c < 4; c++) begin : g_div
      qtci_divider u_div (
         .clock (clock),
         .en    (advance),
         .dvd   (ox_ff[c]),
         .dvs   ((c % 2 == 0) ? ux : uy),
         .quo   (quo[c])
      );
   end

   qtci_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .ctl       (ctl_ff[DIV_STAGES]),
      .lx        (quo[0]),
      .ty        (quo[1]),
      .rx        (quo[2]),
      .by        (quo[3]),
      .depth     (depth_eff),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule
